>>> rtl/fl64ck_pkg.sv
// Package with constants and the modulo reduction shared by the Fletcher-64 checksum block.
package fl64ck_pkg;

    // Field and sum widths.
    localparam int unsigned WORD_W = 32;
    localparam int unsigned SUM_W  = 64;

    // Seed register value after reset.
    localparam logic [SUM_W-1:0] SEED_RESET = 64'h0000_0000_1234_5678;

    // Modulus of the final reduction, 2^32 - 1.
    localparam logic [WORD_W-1:0] MOD_VALUE = 32'hFFFF_FFFF;

    // Reduce a 64-bit sum modulo 2^32 - 1 by end-around folding.
    // Since 2^32 is 1 mod (2^32 - 1), the upper half adds onto the lower half.
    // The second fold cannot carry again, and the modulus itself maps to zero.
    function automatic logic [WORD_W-1:0] mod_reduce(input logic [SUM_W-1:0] value);
        logic [WORD_W:0]   fold1;
        logic [WORD_W:0]   fold2;
        logic [WORD_W-1:0] result;
        fold1  = {1'b0, value[SUM_W-1:WORD_W]} + {1'b0, value[WORD_W-1:0]};
        fold2  = {1'b0, fold1[WORD_W-1:0]} + {{WORD_W{1'b0}}, fold1[WORD_W]};
        result = fold2[WORD_W-1:0];
        if (result == MOD_VALUE)
        begin
            result = '0;
        end
        return result;
    endfunction

endpackage

>>> rtl/fletcher64_word_checksum.sv
// Fletcher-64 style checksum over a stream of 32-bit words with a configurable seed.
// Output: the sums of a block pass through the final-sum stage, then the output register.
// Throughput: one word per cycle unless word_stall is raised; the running sums take a word at every
// accepted transaction, through two chained 64-bit adders.
// Reset: seed returns to 0x12345678, the sums reload from it, and both pipeline stages empty.
// A seed write reloads both running sums at once.
module fletcher64_word_checksum
(
    input  logic        clk,
    input  logic        rst_n,
    // Seed register write port.
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    // Word input channel.
    input  logic        word_valid,
    output logic        word_stall,
    input  logic [31:0] data_word,
    input  logic        last_word,
    // Checksum output channel.
    output logic        sum_valid,
    input  logic        sum_stall,
    output logic [63:0] checksum
);

    localparam int unsigned WORD_W = fl64ck_pkg::WORD_W;
    localparam int unsigned SUM_W  = fl64ck_pkg::SUM_W;

    logic [SUM_W-1:0]  seed_reg;
    logic [SUM_W-1:0]  first_sum_reg;
    logic [SUM_W-1:0]  first_sum_next;
    logic [SUM_W-1:0]  second_sum_reg;
    logic [SUM_W-1:0]  second_sum_next;
    logic [SUM_W-1:0]  fin_first_reg;
    logic [SUM_W-1:0]  fin_second_reg;
    logic              fin_valid_reg;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  checksum_reg;
    logic              word_accept;
    logic              out_load;
    logic [WORD_W-1:0] red_first;
    logic [WORD_W-1:0] red_second;

    // Handshake: the final-sum stage moves on whenever the output register is free or drained.
    assign out_load    = fin_valid_reg && (!out_valid_reg || !sum_stall);
    assign word_stall  = fin_valid_reg && !out_load;
    assign word_accept = word_valid && !word_stall;

    // Running sum update: the word goes into the first sum, the new first sum into the second.
    assign first_sum_next  = first_sum_reg + {{(SUM_W-WORD_W){1'b0}}, data_word};
    assign second_sum_next = second_sum_reg + first_sum_next;

    // Seed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= fl64ck_pkg::SEED_RESET;
        end
        else if (cfg_wr_en)
        begin
            seed_reg <= cfg_wr_data;
        end
    end

    // Running sums: reload on a seed write or at the end of a block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sum_reg  <= {{(SUM_W-WORD_W){1'b0}}, fl64ck_pkg::SEED_RESET[WORD_W-1:0]};
            second_sum_reg <= {{(SUM_W-WORD_W){1'b0}}, fl64ck_pkg::SEED_RESET[SUM_W-1:WORD_W]};
        end
        else if (cfg_wr_en)
        begin
            first_sum_reg  <= {{(SUM_W-WORD_W){1'b0}}, cfg_wr_data[WORD_W-1:0]};
            second_sum_reg <= {{(SUM_W-WORD_W){1'b0}}, cfg_wr_data[SUM_W-1:WORD_W]};
        end
        else if (word_accept)
        begin
            if (last_word)
            begin
                first_sum_reg  <= {{(SUM_W-WORD_W){1'b0}}, seed_reg[WORD_W-1:0]};
                second_sum_reg <= {{(SUM_W-WORD_W){1'b0}}, seed_reg[SUM_W-1:WORD_W]};
            end
            else
            begin
                first_sum_reg  <= first_sum_next;
                second_sum_reg <= second_sum_next;
            end
        end
    end

    // Final-sum stage: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (word_accept && last_word)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    // Final-sum stage: captured sums of the finished block.
    always_ff @(posedge clk)
    begin
        if (word_accept && last_word)
        begin
            fin_first_reg  <= first_sum_next;
            fin_second_reg <= second_sum_next;
        end
    end

    // Modulo reduction of both final sums.
    assign red_first  = fl64ck_pkg::mod_reduce(fin_first_reg);
    assign red_second = fl64ck_pkg::mod_reduce(fin_second_reg);

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!sum_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: checksum payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            checksum_reg <= {red_second, red_first};
        end
    end

    assign sum_valid = out_valid_reg;
    assign checksum  = checksum_reg;

`ifndef NO_ASSERTIONS
    // A seed write reloads the first sum from the low half of the seed.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> first_sum_reg == {{(SUM_W-WORD_W){1'b0}}, $past(cfg_wr_data[WORD_W-1:0])})
        else $error("first sum not reloaded after seed write");

    // The last word of a block always fills the final-sum stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        word_accept && last_word |=> fin_valid_reg)
        else $error("final-sum stage not loaded on last word");

    // The input only stalls while a finished block waits for the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        word_stall |-> fin_valid_reg && out_valid_reg && sum_stall)
        else $error("input stalled without a blocked result");

    // Both reduced halves stay below the modulus.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> checksum_reg[WORD_W-1:0] != fl64ck_pkg::MOD_VALUE &&
                          checksum_reg[SUM_W-1:WORD_W] != fl64ck_pkg::MOD_VALUE)
        else $error("checksum half not fully reduced");
`endif

endmodule
